// ===== rtl/core/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types, constants and helpers for the strip-to-list primitive
// assembler.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int IDX_W  = 16;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;

  // register map
  localparam cfg_addr_t CFG_VERTEX_COUNT        = 1'b0;
  localparam cfg_addr_t CFG_NOMINAL_INDEX_COUNT = 1'b1;

  localparam idx_t RESTART_INDEX = 16'hFFFF;

  // strip position counter saturates at two held indices
  typedef logic [1:0] run_len_t;
  localparam run_len_t RUN_FULL = 2'd2;

  // first corner in the low bits once packed
  typedef struct packed {
    idx_t corner_third;
    idx_t corner_second;
    idx_t corner_first;
  } tri_t;

  localparam int TRI_W = $bits(tri_t);

  // queue status seen by the front and the back
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  function automatic idx_t swap_bytes(input idx_t v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// ===== rtl/core/triangle_strip_to_list.sv =====
// ----------------------------------------------------------------------------
// triangle_strip_to_list
// Primitive assembly: triangle strip with restart to triangle list.
// ----------------------------------------------------------------------------
// Takes one big-endian 16-bit strip index per transaction and emits zero or
// one triangle of three byte-swapped corners. 0xFFFF restarts the strip; from
// the third index of a strip onward each index closes a triangle, with the
// first two corners swapped at odd positions to keep the winding. Triangles
// with repeated corners are dropped, and nothing is emitted while
// vertex_count is zero or nominal_index_count is two or less. tlast on the
// input marks the mesh end and clears the strip state after that index.
// Rate: one index per clock, sustained while the queue has room; the front
// updates its strip state on each accepted index. An accepted triangle passes
// the triangle queue and then the output register on its way to out_tvalid.
// The input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module triangle_strip_to_list #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  tsl_pkg::cfg_addr_t   cfg_addr,   // 0: vertex_count, 1: nominal_index_count
  input  tsl_pkg::cfg_data_t   cfg_wdata,
  // strip index stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tsl_pkg::idx_t        in_tdata,   // [15:0] raw_index
  input  logic                 in_tlast,   // mesh_end
  // triangle stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [tsl_pkg::TRI_W-1:0] out_tdata // [15:0] corner_first,
                                              // [31:16] corner_second,
                                              // [47:32] corner_third
);
  import tsl_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  tri_t    push_tri;
  tri_t    pop_tri;

  // front: strip state and triangle forming
  tsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_tri  (push_tri)
  );

  // decoupling queue
  tsl_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tri (push_tri),
    .pop      (pop),
    .pop_tri  (pop_tri),
    .q_stat   (q_stat)
  );

  // back: output register
  tsl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_tri    (pop_tri),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // degenerate triangles never reach the output
  a_no_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != out_tdata[31:16]) &&
                   (out_tdata[15:0] != out_tdata[47:32]) &&
                   (out_tdata[31:16] != out_tdata[47:32]))
    else $error("degenerate triangle on output");

  // a restart index never produces a triangle
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata == RESTART_INDEX)) |-> !push)
    else $error("triangle formed on restart index");

  // the queue never takes a push when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full triangle queue");

  // nothing pops from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty triangle queue");

  // output is idle straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// ===== rtl/core/tsl_front.sv =====
// ----------------------------------------------------------------------------
// tsl_front
// Takes strip indices, tracks strip state and forms candidate triangles.
// ----------------------------------------------------------------------------
module tsl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  tsl_pkg::cfg_addr_t cfg_addr,
  input  tsl_pkg::cfg_data_t cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tsl_pkg::idx_t      in_tdata,
  input  logic               in_tlast,
  input  tsl_pkg::q_stat_t   q_stat,
  output logic               push,
  output tsl_pkg::tri_t      push_tri
);
  import tsl_pkg::*;

  logic [15:0] vertex_count_r;
  logic [31:0] nominal_index_count_r;
  idx_t        older_r, older_nxt;
  idx_t        newer_r, newer_nxt;
  run_len_t    run_len_r, run_len_nxt;
  logic        odd_r, odd_nxt;

  logic accept;
  logic restart;
  logic enabled;
  idx_t a, b, c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r        <= '0;
      nominal_index_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_VERTEX_COUNT:        vertex_count_r        <= cfg_wdata[15:0];
        CFG_NOMINAL_INDEX_COUNT: nominal_index_count_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign restart   = (in_tdata == RESTART_INDEX);
  assign enabled   = (vertex_count_r != '0) && (nominal_index_count_r > 32'd2);

  // odd positions swap the first two corners
  assign a = swap_bytes(odd_r ? newer_r : older_r);
  assign b = swap_bytes(odd_r ? older_r : newer_r);
  assign c = swap_bytes(in_tdata);

  assign push_tri = '{corner_third: c, corner_second: b, corner_first: a};
  assign push = accept && !restart && (run_len_r == RUN_FULL) && enabled
                && (a != b) && (a != c) && (b != c);

  always_comb begin
    older_nxt   = older_r;
    newer_nxt   = newer_r;
    run_len_nxt = run_len_r;
    odd_nxt     = odd_r;
    if (accept) begin
      priority if (in_tlast) begin
        older_nxt   = '0;
        newer_nxt   = '0;
        run_len_nxt = '0;
        odd_nxt     = 1'b0;
      end else if (restart) begin
        run_len_nxt = '0;
        odd_nxt     = 1'b0;
      end else begin
        older_nxt   = newer_r;
        newer_nxt   = in_tdata;
        run_len_nxt = (run_len_r == RUN_FULL) ? RUN_FULL : run_len_r + 2'd1;
        odd_nxt     = !odd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r   <= '0;
      newer_r   <= '0;
      run_len_r <= '0;
      odd_r     <= 1'b0;
    end else begin
      older_r   <= older_nxt;
      newer_r   <= newer_nxt;
      run_len_r <= run_len_nxt;
      odd_r     <= odd_nxt;
    end
  end

endmodule

// ===== rtl/core/tsl_queue.sv =====
// ----------------------------------------------------------------------------
// tsl_queue
// Small FIFO of triangles between the front and the back.
// ----------------------------------------------------------------------------
module tsl_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsl_pkg::tri_t    push_tri,
  input  logic             pop,
  output tsl_pkg::tri_t    pop_tri,
  output tsl_pkg::q_stat_t q_stat
);
  import tsl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tri_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.not_empty = (count_r != '0);
  assign q_stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_tri          = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/tsl_back.sv =====
// ----------------------------------------------------------------------------
// tsl_back
// Output register: draws triangles from the queue and presents them.
// ----------------------------------------------------------------------------
module tsl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsl_pkg::q_stat_t     q_stat,
  input  tsl_pkg::tri_t        pop_tri,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [tsl_pkg::TRI_W-1:0] out_tdata
);
  import tsl_pkg::*;

  logic out_valid_r, out_valid_nxt;
  tri_t out_tri_r;

  // refill whenever the register is empty or being drained
  assign pop = q_stat.not_empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tri_r <= pop_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tri_r;

endmodule
